// ===== rtl/stl_pkg.sv =====
package stl_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_COMMENT, M_DASH, M_LPAREN, M_EQ, M_GT,
        M_LT, M_COLON, M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE
    } t_mode;

    typedef logic [5:0] t_kind;

    localparam t_kind K_EOF        = 6'd0;
    localparam t_kind K_UNKNOWN    = 6'd1;
    localparam t_kind K_BADCHAR    = 6'd2;
    localparam t_kind K_IDENT      = 6'd3;
    localparam t_kind K_NUM        = 6'd4;
    localparam t_kind K_CHAR       = 6'd5;
    localparam t_kind K_KW0        = 6'd6;
    localparam t_kind K_LPAREN     = 6'd22;
    localparam t_kind K_UNIT       = 6'd23;
    localparam t_kind K_RPAREN     = 6'd24;
    localparam t_kind K_LBRACKET   = 6'd25;
    localparam t_kind K_RBRACKET   = 6'd26;
    localparam t_kind K_LBRACE     = 6'd27;
    localparam t_kind K_RBRACE     = 6'd28;
    localparam t_kind K_SEMI       = 6'd29;
    localparam t_kind K_PIPE       = 6'd30;
    localparam t_kind K_EQ         = 6'd31;
    localparam t_kind K_EQUAL      = 6'd32;
    localparam t_kind K_WIDE_ARROW = 6'd33;
    localparam t_kind K_GT         = 6'd34;
    localparam t_kind K_GE         = 6'd35;
    localparam t_kind K_LT         = 6'd36;
    localparam t_kind K_LE         = 6'd37;
    localparam t_kind K_ADD        = 6'd38;
    localparam t_kind K_SUB        = 6'd39;
    localparam t_kind K_ARROW      = 6'd40;
    localparam t_kind K_MUL        = 6'd41;
    localparam t_kind K_DIV        = 6'd42;
    localparam t_kind K_COLON      = 6'd43;
    localparam t_kind K_DCOLON     = 6'd44;

    // keyword text, first byte lowest, and its length
    localparam logic [39:0] KW_TEXT [16] = '{
        40'h0000006669, 40'h0000006e69, 40'h006e656874, 40'h0065757274,
        40'h0065736c65, 40'h0065736163, 40'h000074656c, 40'h00006e7566,
        40'h65736c6166, 40'h0000646e61, 40'h000000726f, 40'h000000666f,
        40'h0000746f6e, 40'h0000646f6d, 40'h0000657375, 40'h000000005f
    };
    localparam logic [2:0] KW_LEN [16] = '{
        3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3,
        3'd5, 3'd3, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd1
    };

    typedef struct packed {
        logic  vld;
        t_kind kind;
    } t_tok;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

endpackage

// ===== rtl/stl_kw_match.sv =====
module stl_kw_match #(
    parameter int POSITION_BITS = 24
) (
    input  logic [39:0]              i_prefix,
    input  logic [POSITION_BITS-1:0] i_len,
    output stl_pkg::t_kind           o_kind
);
    import stl_pkg::*;

    // compare the held prefix against every keyword in parallel
    always_comb begin
        logic [39:0] mask;
        o_kind = K_IDENT;
        for (int k = 15; k >= 0; k--) begin
            mask = (40'd1 << (8 * KW_LEN[k])) - 40'd1;
            if (i_len == POSITION_BITS'(KW_LEN[k]) && (i_prefix & mask) == KW_TEXT[k])
                o_kind = K_KW0 + 6'(k);
        end
    end
endmodule

// ===== rtl/stl_scan.sv =====
module stl_scan (
    input  logic [7:0]         i_c,
    input  stl_pkg::t_mode     i_mode,
    input  logic               i_end,
    input  stl_pkg::t_kind     i_word_kind,
    output stl_pkg::t_tok      o_tok0,
    output stl_pkg::t_tok      o_tok1,
    output stl_pkg::t_mode     o_mode,
    output logic               o_begin,   // a new pending token starts here
    output logic               o_grow,    // byte joins the pending token
    output logic               o_newline
);
    import stl_pkg::*;

    t_kind k1;      // kind for the pending token when not paired
    t_kind k2;      // paired kind
    logic [7:0] sec;
    logic pair;
    logic rescan;
    t_mode idle_mode;
    t_tok  idle_tok;
    logic  idle_begin;
    logic  idle_nl;

    // single-byte scan from idle
    always_comb begin
        idle_mode  = M_IDLE;
        idle_begin = 1'b0;
        idle_nl    = 1'b0;
        idle_tok   = '{vld: 1'b1, kind: K_UNKNOWN};
        case (i_c)
            8'h20, 8'h0d, 8'h09: idle_tok.vld = 1'b0;
            8'h0a: begin idle_tok.vld = 1'b0; idle_nl = 1'b1; end
            8'h28: begin idle_mode = M_LPAREN; idle_begin = 1'b1; end
            8'h3d: begin idle_mode = M_EQ; idle_begin = 1'b1; end
            8'h3e: begin idle_mode = M_GT; idle_begin = 1'b1; end
            8'h3c: begin idle_mode = M_LT; idle_begin = 1'b1; end
            8'h3a: begin idle_mode = M_COLON; idle_begin = 1'b1; end
            8'h2d: begin idle_mode = M_DASH; idle_begin = 1'b1; end
            8'h27: begin idle_mode = M_CHAR_OPEN; idle_begin = 1'b1; end
            8'h29: idle_tok.kind = K_RPAREN;
            8'h5b: idle_tok.kind = K_LBRACKET;
            8'h5d: idle_tok.kind = K_RBRACKET;
            8'h7b: idle_tok.kind = K_LBRACE;
            8'h7d: idle_tok.kind = K_RBRACE;
            8'h3b: idle_tok.kind = K_SEMI;
            8'h7c: idle_tok.kind = K_PIPE;
            8'h2b: idle_tok.kind = K_ADD;
            8'h2a: idle_tok.kind = K_MUL;
            8'h2f: idle_tok.kind = K_DIV;
            default: begin
                if (is_letter(i_c)) begin
                    idle_mode = M_IDENT; idle_begin = 1'b1;
                end else if (is_num(i_c)) begin
                    idle_mode = M_NUMBER; idle_begin = 1'b1;
                end
            end
        endcase
        if (idle_begin)
            idle_tok.vld = 1'b0;
    end

    // pairing table of the two-byte tokens and the closing quote, with the unpaired kind of each mode
    always_comb begin
        sec = 8'h00; k1 = K_SUB; k2 = K_ARROW;
        case (i_mode)
            M_DASH:       begin sec = 8'h3e; k1 = K_SUB;     k2 = K_ARROW;  end
            M_LPAREN:     begin sec = 8'h29; k1 = K_LPAREN;  k2 = K_UNIT;   end
            M_EQ:         begin
                sec = (i_c == 8'h3e) ? 8'h3e : 8'h3d; k1 = K_EQ;
                k2  = (i_c == 8'h3e) ? K_WIDE_ARROW : K_EQUAL;
            end
            M_GT:         begin sec = 8'h3d; k1 = K_GT;      k2 = K_GE;     end
            M_LT:         begin sec = 8'h3d; k1 = K_LT;      k2 = K_LE;     end
            M_COLON:      begin sec = 8'h3a; k1 = K_COLON;   k2 = K_DCOLON; end
            M_CHAR_CLOSE: begin sec = 8'h27; k1 = K_BADCHAR; k2 = K_CHAR;   end
            M_CHAR_OPEN, M_CHAR_ESC: k1 = K_BADCHAR;
            M_IDENT:      k1 = i_word_kind;
            M_NUMBER:     k1 = K_NUM;
            default:      k1 = K_SUB;
        endcase
        pair = (i_c == sec);
    end

    // main decision for one byte
    always_comb begin
        o_tok0    = '{vld: 1'b0, kind: k1};
        o_tok1    = '{vld: 1'b0, kind: K_EOF};
        o_mode    = i_mode;
        o_begin   = 1'b0;
        o_grow    = 1'b0;
        o_newline = 1'b0;
        rescan    = 1'b0;
        if (i_end) begin
            o_tok0.vld = (i_mode != M_IDLE) && (i_mode != M_COMMENT);
            o_tok1.vld = 1'b1;
            o_mode     = M_IDLE;
        end else begin
            case (i_mode)
                M_IDENT: begin
                    if (is_letter(i_c) || is_num(i_c)) o_grow = 1'b1;
                    else begin o_tok0.vld = 1'b1; rescan = 1'b1; end
                end
                M_NUMBER: begin
                    if (is_num(i_c) || i_c == 8'h5f) o_grow = 1'b1;
                    else begin o_tok0.vld = 1'b1; rescan = 1'b1; end
                end
                M_COMMENT: begin
                    if (i_c == 8'h0a) begin o_mode = M_IDLE; o_newline = 1'b1; end
                end
                M_CHAR_OPEN: begin
                    o_grow = 1'b1;
                    o_mode = (i_c == 8'h5c) ? M_CHAR_ESC : M_CHAR_CLOSE;
                end
                M_CHAR_ESC: begin
                    o_grow = 1'b1;
                    o_mode = M_CHAR_CLOSE;
                end
                M_DASH, M_LPAREN, M_EQ, M_GT, M_LT, M_COLON, M_CHAR_CLOSE: begin
                    if (i_mode == M_DASH && i_c == 8'h2d) o_mode = M_COMMENT;
                    else if (pair) begin
                        o_grow = 1'b1; o_tok0.vld = 1'b1; o_tok0.kind = k2;
                        o_mode = M_IDLE;
                    end else begin
                        o_tok0.vld = 1'b1; rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase
            if (rescan) begin
                o_tok1    = idle_tok;
                o_mode    = idle_mode;
                o_begin   = idle_begin;
                o_newline = idle_nl;
            end
        end
    end
endmodule

// ===== rtl/source_token_lexer.sv =====
// Channel | Dir | Fields                                    | Handshake
// in      | in  | byte_value, is_end                        | i_valid / o_stall
// out     | out | token_kind, token_offset, token_length,   | o_valid / i_stall
//         |     | line_number, is_last                      |
//
// One byte per cycle unless o_stall holds it: an item is decoded in the cycle
// it is accepted and its tokens (up to two) go into a two-entry output queue.
// A second token from the same byte is queued behind the first; input
// stalls only while the queue lacks room for two tokens.
// Reset (synchronous, active low) returns the scanner to line 1, offset 0.
// Results are registered: a byte's first token is output in the cycle after acceptance.
module source_token_lexer #(
    parameter int POSITION_BITS = 24,
    parameter int LINE_BITS     = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_byte_value,
    input  logic                     i_is_end,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [5:0]               o_token_kind,
    output logic [POSITION_BITS-1:0] o_token_offset,
    output logic [POSITION_BITS-1:0] o_token_length,
    output logic [LINE_BITS-1:0]     o_line_number,
    output logic                     o_is_last
);
    import stl_pkg::*;

    localparam int QW = 6 + 2 * POSITION_BITS + LINE_BITS + 1;
    localparam logic [POSITION_BITS-1:0] LEN_MAX = '1;
    localparam logic [LINE_BITS-1:0]     LINE_MAX = '1;

    t_mode                    r_mode, n_mode;
    logic [39:0]              r_prefix, n_prefix;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [POSITION_BITS-1:0] r_len, n_len;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [LINE_BITS-1:0]     r_line, n_line;

    logic [QW-1:0] r_q [2];
    logic [QW-1:0] n_q [2];
    logic [1:0]    r_cnt, n_cnt;

    t_kind word_kind;
    t_tok  tok0, tok1;
    t_mode s_mode;
    logic  s_begin, s_grow, s_nl;
    logic  acc, pop;
    logic [QW-1:0] e0, e1;
    logic [LINE_BITS-1:0] line_tok1;

    stl_kw_match #(.POSITION_BITS(POSITION_BITS)) u_kw (
        .i_prefix (r_prefix),
        .i_len    (r_len),
        .o_kind   (word_kind)
    );

    stl_scan u_scan (
        .i_c         (i_byte_value),
        .i_mode      (r_mode),
        .i_end       (i_is_end),
        .i_word_kind (word_kind),
        .o_tok0      (tok0),
        .o_tok1      (tok1),
        .o_mode      (s_mode),
        .o_begin     (s_begin),
        .o_grow      (s_grow),
        .o_newline   (s_nl)
    );

    assign o_stall = (r_cnt == 2'd2) || (r_cnt == 2'd1 && i_stall);
    assign acc     = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    // scanner state update
    always_comb begin
        n_mode   = s_mode;
        n_prefix = r_prefix;
        n_start  = r_start;
        n_len    = r_len;
        n_pos    = r_pos + POSITION_BITS'(1);
        n_line   = r_line;
        if (s_grow) begin
            if (r_mode == M_IDENT && r_len < POSITION_BITS'(5))
                n_prefix = r_prefix | (40'(i_byte_value) << (8 * r_len[2:0]));
            if (r_len != LEN_MAX)
                n_len = r_len + POSITION_BITS'(1);
        end
        if (s_begin) begin
            n_start  = r_pos;
            n_len    = POSITION_BITS'(1);
            n_prefix = 40'(i_byte_value);
        end
        if (s_nl && r_line != LINE_MAX)
            n_line = r_line + LINE_BITS'(1);
        if (i_is_end) begin
            n_mode = M_IDLE; n_prefix = '0; n_start = '0; n_len = '0;
            n_pos = '0; n_line = LINE_BITS'(1);
        end
    end

    // token records; a paired token takes the grown length
    assign line_tok1 = r_line;
    always_comb begin
        logic [POSITION_BITS-1:0] l0;
        l0 = r_len;
        if (tok0.kind != tok1.kind && s_grow && tok0.vld && r_len != LEN_MAX)
            l0 = r_len + POSITION_BITS'(1);
        e0 = {tok0.kind, r_start, l0, r_line, !tok1.vld};
        e1 = {tok1.kind, r_pos,
              tok1.kind == K_EOF ? POSITION_BITS'(0) : POSITION_BITS'(1),
              line_tok1, 1'b1};
    end

    // two-entry output queue: pop first, then append this item's tokens
    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (pop) begin
            n_q[0] = r_q[1];
            n_cnt  = n_cnt - 2'd1;
        end
        if (acc) begin
            if (tok0.vld && tok1.vld) begin
                n_q[n_cnt[0]] = e0; n_q[1] = e1; n_cnt = n_cnt + 2'd2;
            end else if (tok0.vld) begin
                n_q[n_cnt[0]] = e0; n_cnt = n_cnt + 2'd1;
            end else if (tok1.vld) begin
                n_q[n_cnt[0]] = e1; n_cnt = n_cnt + 2'd1;
            end
        end
    end

    // scanner and queue registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_prefix <= '0; r_start <= '0; r_len <= '0;
            r_pos <= '0; r_line <= LINE_BITS'(1); r_cnt <= '0;
        end else begin
            if (acc) begin
                r_mode <= n_mode; r_prefix <= n_prefix; r_start <= n_start;
                r_len <= n_len; r_pos <= n_pos; r_line <= n_line;
            end
            r_q   <= n_q;
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = r_cnt != 2'd0;
    assign {o_token_kind, o_token_offset, o_token_length, o_line_number, o_is_last} = r_q[0];

    // queue never overfills
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue overflow");
    // no accept while full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !acc) else $error("accept while full");
    // end of source resets position
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_is_end |=> r_pos == '0) else $error("position not cleared");
endmodule
